@@ rtl/cgem_pkg.sv @@
package cgem_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int MAX_POINTS = 16;
   localparam int PT_IDX_W = $clog2(MAX_POINTS);
   localparam int PT_CNT_W = 5;
   localparam int GAIN_W = 17;
   localparam int POS_W = 32;
   localparam int FADE_W = 24;
   localparam int RATE_W = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SUM_W = SAMPLE_BITS + 2;
   localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

   localparam int DIV_Q_W = 17;
   localparam int DIV_D_W = 32;
   localparam int DIV_A_W = DIV_D_W + DIV_Q_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   localparam logic [GAIN_W-1:0] UNITY = 17'h10000;
   localparam logic [POS_W-1:0] FALLBACK_RATE = 32'd48000;

   localparam logic REQ_LOAD = 1'b0;

   localparam logic [1:0] ROUTE_LEFT = 2'd1;
   localparam logic [1:0] ROUTE_RIGHT = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_VOLUME = 3'd0,
      CSR_PLAYBACK_SCALE = 3'd1,
      CSR_FADE_IN = 3'd2,
      CSR_FADE_OUT = 3'd3,
      CSR_DURATION = 3'd4,
      CSR_DECODER_RATE = 3'd5,
      CSR_CHANNEL_ROUTE = 3'd6,
      CSR_POINT_COUNT = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_PASS,
      KIND_ZERO,
      KIND_MIX
   } item_kind_type;

   typedef struct packed {
      logic [GAIN_W-1:0] target_volume;
      logic [GAIN_W-1:0] playback_scale;
      logic [FADE_W-1:0] fade_in_frames;
      logic [FADE_W-1:0] fade_out_frames;
      logic [POS_W-1:0] duration_frames;
      logic [RATE_W-1:0] decoder_rate;
      logic [1:0] channel_route;
      logic [PT_CNT_W-1:0] point_count;
   } cfg_type;

   typedef struct packed {
      item_kind_type kind;
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
      logic signed [SAMPLE_BITS-1:0] mix_left;
      logic signed [SAMPLE_BITS-1:0] mix_right;
      logic [POS_W-1:0] frame_pos;
      logic [3:0] point_index;
      logic [GAIN_W-1:0] point_x;
      logic [GAIN_W-1:0] point_y;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_FI,
      ST_FO_CHK,
      ST_DIV_FO,
      ST_RAMP_MUL,
      ST_DIV_T,
      ST_TAB_RD0,
      ST_TAB_CHK0,
      ST_TAB_CHKL,
      ST_TAB_SCAN,
      ST_INTERP_DIV,
      ST_DIV_E,
      ST_GAIN_MUL,
      ST_GAIN_SAT,
      ST_SAMPLE_MUL,
      ST_SUM,
      ST_EMIT
   } back_state_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         return hi[SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

endpackage

@@ rtl/cgem_if.sv @@
interface cgem_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic signed [cgem_pkg::SAMPLE_BITS-1:0] sample_left;
   logic signed [cgem_pkg::SAMPLE_BITS-1:0] sample_right;
   logic signed [cgem_pkg::SAMPLE_BITS-1:0] mix_left;
   logic signed [cgem_pkg::SAMPLE_BITS-1:0] mix_right;
   logic [cgem_pkg::POS_W-1:0] frame_pos;
   logic frame_present;
   logic paused;
   logic [3:0] point_index;
   logic [cgem_pkg::GAIN_W-1:0] point_x;
   logic [cgem_pkg::GAIN_W-1:0] point_y;

   modport source(output valid, req_type, sample_left, sample_right, mix_left, mix_right,
      frame_pos, frame_present, paused, point_index, point_x, point_y, input ready);
   modport sink(input valid, req_type, sample_left, sample_right, mix_left, mix_right,
      frame_pos, frame_present, paused, point_index, point_x, point_y, output ready);
endinterface

interface cgem_rsp_if;
   logic valid;
   logic ready;
   logic signed [cgem_pkg::SAMPLE_BITS-1:0] out_left;
   logic signed [cgem_pkg::SAMPLE_BITS-1:0] out_right;
   logic [cgem_pkg::GAIN_W-1:0] applied_gain;

   modport source(output valid, out_left, out_right, applied_gain, input ready);
   modport sink(input valid, out_left, out_right, applied_gain, output ready);
endinterface

@@ rtl/cgem_front.sv @@
module cgem_front (
   cgem_req_if.sink req_chan,
   output logic push_valid,
   output cgem_pkg::item_type push_item,
   input logic push_ready
);

   cgem_pkg::item_kind_type kind;

   always_comb begin
      if (req_chan.req_type == cgem_pkg::REQ_LOAD) begin
         kind = cgem_pkg::KIND_LOAD;
      end else if (req_chan.paused) begin
         kind = cgem_pkg::KIND_PASS;
      end else if (!req_chan.frame_present) begin
         kind = cgem_pkg::KIND_ZERO;
      end else begin
         kind = cgem_pkg::KIND_MIX;
      end
   end

   always_comb begin
      push_item.kind = kind;
      push_item.sample_left = req_chan.sample_left;
      push_item.sample_right = req_chan.sample_right;
      push_item.mix_left = req_chan.mix_left;
      push_item.mix_right = req_chan.mix_right;
      push_item.frame_pos = req_chan.frame_pos;
      push_item.point_index = req_chan.point_index;
      push_item.point_x = req_chan.point_x;
      push_item.point_y = req_chan.point_y;
   end

   assign push_valid = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

@@ rtl/cgem_queue.sv @@
module cgem_queue (
   input logic clock,
   input logic reset,
   input logic push_valid,
   input cgem_pkg::item_type push_item,
   output logic push_ready,
   output logic pop_valid,
   output cgem_pkg::item_type pop_item,
   input logic pop_ready
);

   cgem_pkg::item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/cgem_div.sv @@
module cgem_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [cgem_pkg::DIV_A_W-1:0] dividend,
   input logic [cgem_pkg::DIV_D_W-1:0] divisor,
   output logic done,
   output logic [cgem_pkg::DIV_Q_W-1:0] quotient
);

   localparam int QW = cgem_pkg::DIV_Q_W;
   localparam int DW = cgem_pkg::DIV_D_W;

   logic [DW-1:0] rem_ff;
   logic [QW-1:0] quo_ff;
   logic [DW-1:0] div_ff;
   logic [cgem_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [DW:0] trial;
   logic [DW:0] diff;
   logic fits;

   // one quotient bit per cycle; caller keeps dividend < divisor << QW
   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      diff = trial - {1'b0, div_ff};
      fits = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      if (start) begin
         cnt_in = cgem_pkg::DIV_CNT_W'(QW);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
      done_in = !start && (cnt_ff == cgem_pkg::DIV_CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[cgem_pkg::DIV_A_W-1:QW];
         quo_ff <= dividend[QW-1:0];
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_ff <= {quo_ff[QW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/cgem_back.sv @@
module cgem_back (
   input logic clock,
   input logic reset,
   input cgem_pkg::cfg_type cfg,
   input logic pop_valid,
   input cgem_pkg::item_type pop_item,
   output logic pop_ready,
   cgem_rsp_if.source rsp_chan
);

   localparam int GW = cgem_pkg::GAIN_W;
   localparam int SB = cgem_pkg::SAMPLE_BITS;
   localparam int IW = cgem_pkg::PT_IDX_W;

   cgem_pkg::back_state_type state_ff, state_in;
   cgem_pkg::item_type item_ff;

   logic [2*GW-1:0] pt_mem [cgem_pkg::MAX_POINTS];
   logic [IW-1:0] rd_addr;
   logic [GW-1:0] rd_x_ff, rd_y_ff;

   logic [GW-1:0] t_ff, env_ff, fi_ff, fo_ff, prev_x_ff, prev_y_ff, span_ff, gain_ff;
   logic [2*GW-1:0] tvs_ff, p0_ff, p1_ff;
   logic [2*GW:0] g1_ff;
   logic [IW-1:0] k_ff;
   logic signed [cgem_pkg::PROD_W-1:0] prod_l_ff, prod_r_ff;
   logic signed [SB-1:0] res_l_ff, res_r_ff;
   logic [GW-1:0] res_g_ff;

   logic out_valid_ff, out_valid_in;
   logic signed [SB-1:0] out_l_ff, out_r_ff;
   logic [GW-1:0] out_g_ff;

   logic [cgem_pkg::POS_W-1:0] dur, rem_frames;
   logic [cgem_pkg::PT_CNT_W-1:0] n_pts;
   logic [IW-1:0] last_idx;
   logic fi_active, fo_active, in_seg, slot_free, load_ok, out_load;

   logic div_start, div_done;
   logic [cgem_pkg::DIV_A_W-1:0] div_a;
   logic [cgem_pkg::DIV_D_W-1:0] div_d;
   logic [cgem_pkg::DIV_Q_W-1:0] div_q;

   logic signed [cgem_pkg::SUM_W-1:0] l_term, r_term;

   cgem_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_a),
      .divisor(div_d),
      .done(div_done),
      .quotient(div_q)
   );

   always_comb begin
      if (cfg.duration_frames != '0) begin
         dur = cfg.duration_frames;
      end else if (cfg.decoder_rate != '0) begin
         dur = cgem_pkg::POS_W'(cfg.decoder_rate);
      end else begin
         dur = cgem_pkg::FALLBACK_RATE;
      end
      rem_frames = (item_ff.frame_pos >= dur) ? '0 : dur - item_ff.frame_pos;
      n_pts = (cfg.point_count > cgem_pkg::PT_CNT_W'(cgem_pkg::MAX_POINTS))
         ? cgem_pkg::PT_CNT_W'(cgem_pkg::MAX_POINTS) : cfg.point_count;
      last_idx = IW'(n_pts - 1'b1);
      fi_active = (cfg.fade_in_frames != '0)
         && (item_ff.frame_pos < cgem_pkg::POS_W'(cfg.fade_in_frames));
      fo_active = (cfg.fade_out_frames != '0)
         && (rem_frames < cgem_pkg::POS_W'(cfg.fade_out_frames));
      in_seg = (t_ff >= prev_x_ff) && (t_ff <= rd_x_ff);
      slot_free = !out_valid_ff || rsp_chan.ready;
      load_ok = (32'(pop_item.point_index) < cgem_pkg::MAX_POINTS);
      l_term = prod_l_ff[cgem_pkg::SUM_W+15:16];
      r_term = prod_r_ff[cgem_pkg::SUM_W+15:16];
      if (cfg.channel_route == cgem_pkg::ROUTE_LEFT) begin
         r_term = '0;
      end else if (cfg.channel_route == cgem_pkg::ROUTE_RIGHT) begin
         l_term = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cgem_pkg::ST_IDLE: begin
            if (pop_valid) begin
               case (pop_item.kind)
                  cgem_pkg::KIND_LOAD: state_in = cgem_pkg::ST_IDLE;
                  cgem_pkg::KIND_MIX: state_in = cgem_pkg::ST_PREP;
                  default: state_in = cgem_pkg::ST_EMIT;
               endcase
            end
         end
         cgem_pkg::ST_PREP: begin
            if (n_pts == '0) begin
               state_in = fi_active ? cgem_pkg::ST_DIV_FI : cgem_pkg::ST_FO_CHK;
            end else begin
               state_in = (item_ff.frame_pos >= dur) ? cgem_pkg::ST_TAB_RD0
                  : cgem_pkg::ST_DIV_T;
            end
         end
         cgem_pkg::ST_DIV_FI: if (div_done) state_in = cgem_pkg::ST_FO_CHK;
         cgem_pkg::ST_FO_CHK: begin
            state_in = fo_active ? cgem_pkg::ST_DIV_FO : cgem_pkg::ST_RAMP_MUL;
         end
         cgem_pkg::ST_DIV_FO: if (div_done) state_in = cgem_pkg::ST_RAMP_MUL;
         cgem_pkg::ST_RAMP_MUL: state_in = cgem_pkg::ST_GAIN_MUL;
         cgem_pkg::ST_DIV_T: if (div_done) state_in = cgem_pkg::ST_TAB_RD0;
         cgem_pkg::ST_TAB_RD0: state_in = cgem_pkg::ST_TAB_CHK0;
         cgem_pkg::ST_TAB_CHK0: begin
            state_in = (t_ff <= rd_x_ff) ? cgem_pkg::ST_GAIN_MUL : cgem_pkg::ST_TAB_CHKL;
         end
         cgem_pkg::ST_TAB_CHKL: begin
            state_in = (t_ff >= rd_x_ff) ? cgem_pkg::ST_GAIN_MUL : cgem_pkg::ST_TAB_SCAN;
         end
         cgem_pkg::ST_TAB_SCAN: begin
            if (in_seg) begin
               state_in = (rd_x_ff == prev_x_ff) ? cgem_pkg::ST_GAIN_MUL
                  : cgem_pkg::ST_INTERP_DIV;
            end else if (k_ff == last_idx) begin
               state_in = cgem_pkg::ST_GAIN_MUL;
            end
         end
         cgem_pkg::ST_INTERP_DIV: state_in = cgem_pkg::ST_DIV_E;
         cgem_pkg::ST_DIV_E: if (div_done) state_in = cgem_pkg::ST_GAIN_MUL;
         cgem_pkg::ST_GAIN_MUL: state_in = cgem_pkg::ST_GAIN_SAT;
         cgem_pkg::ST_GAIN_SAT: state_in = cgem_pkg::ST_SAMPLE_MUL;
         cgem_pkg::ST_SAMPLE_MUL: state_in = cgem_pkg::ST_SUM;
         cgem_pkg::ST_SUM: state_in = cgem_pkg::ST_EMIT;
         cgem_pkg::ST_EMIT: if (slot_free) state_in = cgem_pkg::ST_IDLE;
         default: state_in = cgem_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop_ready = 1'b0;
      div_start = 1'b0;
      div_a = '0;
      div_d = '0;
      rd_addr = '0;
      out_load = 1'b0;
      case (state_ff)
         cgem_pkg::ST_IDLE: pop_ready = 1'b1;
         cgem_pkg::ST_PREP: begin
            div_a = {item_ff.frame_pos, 16'b0, 1'b0} >> 1;
            if (n_pts == '0) begin
               div_start = fi_active;
               div_d = cgem_pkg::DIV_D_W'(cfg.fade_in_frames);
            end else begin
               div_start = (item_ff.frame_pos < dur);
               div_d = dur;
            end
         end
         cgem_pkg::ST_FO_CHK: begin
            div_start = fo_active;
            div_a = {rem_frames, 16'b0, 1'b0} >> 1;
            div_d = cgem_pkg::DIV_D_W'(cfg.fade_out_frames);
         end
         cgem_pkg::ST_TAB_CHK0: rd_addr = last_idx;
         cgem_pkg::ST_TAB_CHKL: rd_addr = IW'(1);
         cgem_pkg::ST_TAB_SCAN: rd_addr = k_ff + 1'b1;
         cgem_pkg::ST_INTERP_DIV: begin
            div_start = 1'b1;
            div_a = cgem_pkg::DIV_A_W'(p0_ff) + cgem_pkg::DIV_A_W'(p1_ff)
               + cgem_pkg::DIV_A_W'(span_ff >> 1);
            div_d = cgem_pkg::DIV_D_W'(span_ff);
         end
         cgem_pkg::ST_EMIT: out_load = slot_free;
         default: pop_ready = 1'b0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgem_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cgem_pkg::ST_IDLE && pop_valid
            && pop_item.kind == cgem_pkg::KIND_LOAD && load_ok) begin
         pt_mem[IW'(pop_item.point_index)] <= {pop_item.point_x, pop_item.point_y};
      end
      {rd_x_ff, rd_y_ff} <= pt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cgem_pkg::ST_IDLE: begin
            item_ff <= pop_item;
            res_g_ff <= '0;
            if (pop_item.kind == cgem_pkg::KIND_PASS) begin
               res_l_ff <= pop_item.mix_left;
               res_r_ff <= pop_item.mix_right;
            end else begin
               res_l_ff <= '0;
               res_r_ff <= '0;
            end
         end
         cgem_pkg::ST_PREP: begin
            tvs_ff <= cfg.target_volume * cfg.playback_scale;
            fi_ff <= cgem_pkg::UNITY;
            t_ff <= cgem_pkg::UNITY;
         end
         cgem_pkg::ST_DIV_FI: fi_ff <= div_q;
         cgem_pkg::ST_FO_CHK: fo_ff <= cgem_pkg::UNITY;
         cgem_pkg::ST_DIV_FO: fo_ff <= div_q;
         cgem_pkg::ST_RAMP_MUL: begin
            env_ff <= GW'(({{GW{1'b0}}, fi_ff} * {{GW{1'b0}}, fo_ff}) >> 16);
         end
         cgem_pkg::ST_DIV_T: t_ff <= div_q;
         cgem_pkg::ST_TAB_CHK0: begin
            env_ff <= rd_y_ff;
            prev_x_ff <= rd_x_ff;
            prev_y_ff <= rd_y_ff;
         end
         cgem_pkg::ST_TAB_CHKL: begin
            env_ff <= rd_y_ff;
            k_ff <= IW'(1);
         end
         cgem_pkg::ST_TAB_SCAN: begin
            env_ff <= in_seg ? prev_y_ff : cgem_pkg::UNITY;
            span_ff <= rd_x_ff - prev_x_ff;
            p0_ff <= prev_y_ff * (rd_x_ff - t_ff);
            p1_ff <= rd_y_ff * (t_ff - prev_x_ff);
            prev_x_ff <= rd_x_ff;
            prev_y_ff <= rd_y_ff;
            k_ff <= k_ff + 1'b1;
         end
         cgem_pkg::ST_DIV_E: env_ff <= div_q;
         cgem_pkg::ST_GAIN_MUL: g1_ff <= tvs_ff[2*GW-1:16] * env_ff;
         cgem_pkg::ST_GAIN_SAT: begin
            gain_ff <= (g1_ff[2*GW:16] > (2*GW-15)'(cgem_pkg::UNITY)) ? cgem_pkg::UNITY
               : g1_ff[GW+15:16];
         end
         cgem_pkg::ST_SAMPLE_MUL: begin
            prod_l_ff <= item_ff.sample_left * $signed({1'b0, gain_ff});
            prod_r_ff <= item_ff.sample_right * $signed({1'b0, gain_ff});
         end
         cgem_pkg::ST_SUM: begin
            res_l_ff <= cgem_pkg::sat_sample(cgem_pkg::SUM_W'(item_ff.mix_left) + l_term);
            res_r_ff <= cgem_pkg::sat_sample(cgem_pkg::SUM_W'(item_ff.mix_right) + r_term);
            res_g_ff <= gain_ff;
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_l_ff <= res_l_ff;
         out_r_ff <= res_r_ff;
         out_g_ff <= res_g_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_left = out_l_ff;
   assign rsp_chan.out_right = out_r_ff;
   assign rsp_chan.applied_gain = out_g_ff;

endmodule

@@ rtl/cue_gain_envelope_mixer.sv @@
// Channel    Dir   Beat
// req_chan   in    load one breakpoint, or one stereo frame with its position
// rsp_chan   out   mixed left/right pair and applied gain, one per frame beat
// csr_*      in    register write, one per cycle, no read-back
//
// Breakpoint loads retire in the idle state; paused or absent frames go
// straight to emit. Ramp frames take up to two passes of the shared
// radix-2 divider; table frames walk their n breakpoints one entry per
// cycle and take up to two divides. A two-beat queue parts intake from
// the sequencer; the result register holds a beat under stall while the
// next item proceeds. Reset is synchronous; the breakpoint table is not
// cleared.
module cue_gain_envelope_mixer (
   input logic clock,
   input logic reset,
   cgem_req_if.sink req_chan,
   cgem_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input logic [cgem_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [cgem_pkg::CSR_DATA_W-1:0] csr_data
);

   cgem_pkg::cfg_type cfg_ff;
   logic push_valid, push_ready, pop_valid, pop_ready;
   cgem_pkg::item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_volume <= cgem_pkg::UNITY;
         cfg_ff.playback_scale <= cgem_pkg::UNITY;
         cfg_ff.fade_in_frames <= '0;
         cfg_ff.fade_out_frames <= '0;
         cfg_ff.duration_frames <= '0;
         cfg_ff.decoder_rate <= cgem_pkg::RATE_W'(cgem_pkg::FALLBACK_RATE);
         cfg_ff.channel_route <= '0;
         cfg_ff.point_count <= '0;
      end else if (csr_write_enable) begin
         case (cgem_pkg::csr_index_type'(csr_index))
            cgem_pkg::CSR_TARGET_VOLUME:
               cfg_ff.target_volume <= csr_data[cgem_pkg::GAIN_W-1:0];
            cgem_pkg::CSR_PLAYBACK_SCALE:
               cfg_ff.playback_scale <= csr_data[cgem_pkg::GAIN_W-1:0];
            cgem_pkg::CSR_FADE_IN: cfg_ff.fade_in_frames <= csr_data[cgem_pkg::FADE_W-1:0];
            cgem_pkg::CSR_FADE_OUT: cfg_ff.fade_out_frames <= csr_data[cgem_pkg::FADE_W-1:0];
            cgem_pkg::CSR_DURATION: cfg_ff.duration_frames <= csr_data[cgem_pkg::POS_W-1:0];
            cgem_pkg::CSR_DECODER_RATE: cfg_ff.decoder_rate <= csr_data[cgem_pkg::RATE_W-1:0];
            cgem_pkg::CSR_CHANNEL_ROUTE: cfg_ff.channel_route <= csr_data[1:0];
            cgem_pkg::CSR_POINT_COUNT: cfg_ff.point_count <= csr_data[cgem_pkg::PT_CNT_W-1:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   cgem_front u_front (
      .req_chan(req_chan),
      .push_valid(push_valid),
      .push_item(push_item),
      .push_ready(push_ready)
   );

   cgem_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_item(push_item),
      .push_ready(push_ready),
      .pop_valid(pop_valid),
      .pop_item(pop_item),
      .pop_ready(pop_ready)
   );

   cgem_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .pop_valid(pop_valid),
      .pop_item(pop_item),
      .pop_ready(pop_ready),
      .rsp_chan(rsp_chan)
   );

endmodule

@@ rtl/cgem_checker.sv @@
module cgem_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_type,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [cgem_pkg::SAMPLE_BITS-1:0] out_left,
   input logic signed [cgem_pkg::SAMPLE_BITS-1:0] out_right,
   input logic [cgem_pkg::GAIN_W-1:0] applied_gain
);

   logic [7:0] pending_ff, pending_in;
   logic frame_in, beat_out;

   assign frame_in = req_valid && req_ready && (req_type != cgem_pkg::REQ_LOAD);
   assign beat_out = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + 8'(frame_in) - 8'(beat_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_left) && $stable(out_right)
         && $stable(applied_gain))
      else $error("rsp payload changed under stall");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      beat_out |-> pending_ff != 8'd0)
      else $error("rsp beat without an outstanding frame");

   a_gain_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> applied_gain <= cgem_pkg::UNITY)
      else $error("applied gain above unity");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind cue_gain_envelope_mixer cgem_checker u_cgem_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_type(req_chan.req_type),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .out_left(rsp_chan.out_left),
   .out_right(rsp_chan.out_right),
   .applied_gain(rsp_chan.applied_gain)
);
